FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ukfq_pkg.sv
// Types and constants of the unique-key FIFO queue.
package ukfq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  // Contents of one queue slot.
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] key;
    logic [DataW-1:0] value;
  } slot_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

FILE: src/ukfq_cell.sv
// One slot of the queue chain: holds an entry, matches keys, shifts toward the head.
module ukfq_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ukfq_pkg::cell_ctrl_t         ctrl_i,
  input  logic [ukfq_pkg::DataW-1:0]   key_i,
  input  logic [ukfq_pkg::DataW-1:0]   value_i,
  input  logic                         prev_valid_i,
  input  ukfq_pkg::slot_t              next_slot_i,
  output ukfq_pkg::slot_t              slot_o,
  output logic                         hit_o
);
  import ukfq_pkg::*;

  logic             valid_q, valid_d;
  logic [DataW-1:0] key_q, key_d;
  logic [DataW-1:0] value_q, value_d;

  // Dequeue shifts the neighbor in; enqueue lands in the first free cell.
  always_comb begin
    priority if (ctrl_i.deq) begin
      valid_d = next_slot_i.valid;
      key_d   = next_slot_i.key;
      value_d = next_slot_i.value;
    end else if (ctrl_i.enq && !valid_q && prev_valid_i) begin
      valid_d = 1'b1;
      key_d   = key_i;
      value_d = value_i;
    end else begin
      valid_d = valid_q;
      key_d   = key_q;
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign slot_o = '{valid: valid_q, key: key_q, value: value_q};
  assign hit_o  = valid_q && (key_q == key_i);

endmodule

FILE: src/unique_key_fifo_queue_unit.sv
// Top level of the unique-key FIFO queue: cell chain, status logic, result register.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------------
//  in       | input     | in_valid_i/in_stall_o | command_i, entry_key_i, entry_value_i
//  out      | output    | out_valid_o/out_stall_i | status_o, out_key_o, out_value_o,
//           |           |                      | occupancy_o, is_empty_o
//
// One transaction per cycle unless the input stalls: a command is resolved in the
// cycle it is accepted and its result shows in the result register on the next cycle.
// The duplicate check compares the key against all DEPTH cells at once.
// Reset empties the chain (valid bits only); slot payloads stay unreset.
// The input stalls only while a result waits and the output is stalled.
`include "assert_macros.svh"

module unique_key_fifo_queue_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       command_i,
  input  logic signed [31:0]         entry_key_i,
  input  logic signed [31:0]         entry_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ukfq_pkg::status_e          status_o,
  output logic signed [31:0]         out_key_o,
  output logic signed [31:0]         out_value_o,
  output logic [ukfq_pkg::CntW-1:0]  occupancy_o,
  output logic                       is_empty_o
);
  import ukfq_pkg::*;

  // Chain state: cell 0 holds the oldest entry, entries are packed from cell 0.
  slot_t             slot   [DEPTH];
  logic [DEPTH-1:0]  valid_vec;
  logic [DEPTH-1:0]  hit_vec;
  cell_ctrl_t        ctrl;

  logic              in_acc;
  logic              is_deq;
  logic              full;
  logic              empty;
  logic              dup;
  status_e           status_d;

  logic [CntW-1:0]   count_q, count_d;

  logic              out_valid_q;
  status_e           status_q;
  logic [DataW-1:0]  out_key_q, out_value_q;
  logic [CntW-1:0]   occ_q;
  logic              is_empty_q;

  // Accept whenever the result register is free or drains this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_deq     = (command_i == CMD_DEQ);

  assign full  = valid_vec[DEPTH-1];
  assign empty = !valid_vec[0];
  assign dup   = |hit_vec;

  // Full check wins over the duplicate check.
  always_comb begin
    if (is_deq) begin
      status_d = empty ? ST_EMPTY : ST_OK;
    end else begin
      priority if (full) status_d = ST_FULL;
      else if (dup)      status_d = ST_DUP;
      else               status_d = ST_OK;
    end
  end

  assign ctrl.enq = in_acc && !is_deq && (status_d == ST_OK);
  assign ctrl.deq = in_acc && is_deq && (status_d == ST_OK);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic  prev_valid;
      slot_t next_slot;

      if (gi == 0) begin : g_head
        assign prev_valid = 1'b1;
      end else begin : g_mid
        assign prev_valid = slot[gi-1].valid;
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign next_slot = '0;
      end else begin : g_body
        assign next_slot = slot[gi+1];
      end

      ukfq_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .key_i        (entry_key_i),
        .value_i      (entry_value_i),
        .prev_valid_i (prev_valid),
        .next_slot_i  (next_slot),
        .slot_o       (slot[gi]),
        .hit_o        (hit_vec[gi])
      );

      assign valid_vec[gi] = slot[gi].valid;
    end
  endgenerate

  // Occupancy counter kept beside the chain for the result fields.
  always_comb begin
    count_d = count_q;
    if (ctrl.enq) count_d = count_q + 1'b1;
    if (ctrl.deq) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; head cell data only on a successful dequeue.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q    <= status_d;
      out_key_q   <= ctrl.deq ? slot[0].key   : '0;
      out_value_q <= ctrl.deq ? slot[0].value : '0;
      occ_q       <= count_d;
      is_empty_q  <= (count_d == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_key_o   = out_key_q;
  assign out_value_o = out_value_q;
  assign occupancy_o = occ_q;
  assign is_empty_o  = is_empty_q;

  // Counter agrees with the number of occupied cells.
  `ASSERT_IMPLIES(a_count_matches, clk_i, rst_ni, 1'b1,
                  count_q == CntW'($countones(valid_vec)), "count out of sync with cells")
  // Occupied cells form an unbroken run starting at the head.
  `ASSERT_IMPLIES(a_packed_chain, clk_i, rst_ni, 1'b1,
                  (valid_vec & (valid_vec + 1'b1)) == '0, "gap in cell chain")
  // A successful enqueue grows the queue by exactly one.
  `ASSERT_NEXT(a_enq_grows, clk_i, rst_ni, ctrl.enq,
               count_q == $past(count_q) + 1'b1, "enqueue did not advance count")

endmodule
